// ===== hdl/deqbg_pkg.sv =====
// Shared constants and helpers for the dynamic EQ band gain computer.
// Used by the top level and by its port checker; depends on nothing else.
package deqbg_pkg;

	// Field widths
	localparam int SAMPLE_W = 24;
	localparam int DB_W     = 16;
	localparam int GAIN_W   = 15;

	// Register indexes (byte address divided by four)
	localparam logic [2:0] REG_MODE      = 3'd0;
	localparam logic [2:0] REG_DETECT    = 3'd1;
	localparam logic [2:0] REG_THRESHOLD = 3'd2;
	localparam logic [2:0] REG_RATIO     = 3'd3;
	localparam logic [2:0] REG_KNEE      = 3'd4;
	localparam logic [2:0] REG_RANGE     = 3'd5;
	localparam logic [2:0] REG_ATTACK    = 3'd6;
	localparam logic [2:0] REG_RELEASE   = 3'd7;

	// Dynamics modes
	localparam logic [1:0] MODE_OFF  = 2'd0;
	localparam logic [1:0] MODE_COMP = 2'd1;
	localparam logic [1:0] MODE_EXP  = 2'd2;
	localparam logic [1:0] MODE_GATE = 2'd3;

	// Level floor of -100 dB and the dB per octave factor (10*log10(2) in Q24)
	localparam logic signed [DB_W-1:0] DB_FLOOR = -16'sd25600;
	localparam logic [25:0] DB_PER_OCTAVE_Q24 = 26'd50504453;
	localparam logic [16:0] COEFF_ONE = 17'd65536;

	// Scale a magnitude by 2^-16, rounding halves upwards.
	function automatic logic [31:0] rnd_q16(input logic [47:0] m);
		logic [47:0] s;
		begin
			s = m + 48'd32768;
			return s[47:16];
		end
	endfunction

	// Saturate a wide signed value to one sample.
	function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [26:0] v);
		begin
			if (v > 27'sd8388607) begin
				return 24'sh7FFFFF;
			end else if (v < -27'sd8388608) begin
				return 24'sh800000;
			end else begin
				return v[23:0];
			end
		end
	endfunction

endpackage

// ===== hdl/dynamic_eq_band_gain_computer_top.sv =====
// Top level of the dynamic EQ band gain computer: register file, sequencer,
// shared multiplier and shared divider. Depends on deqbg_pkg.
//
// One stereo beat is taken at a time; item_ready is high only while the block
// is idle. With the band off a beat goes straight to the done state. Otherwise
// the detector energy is normalised eight or one bit a cycle, the 16 fraction
// bits of the logarithm each take a squaring through the single 32x32
// multiplier, and the 48-step restoring divider runs once for the gain curve
// and once for the blend amount, each run skipped where the result is known
// without dividing. A finished result is held in the output register, and the
// next beat is accepted while it waits to be taken. There is no clearing pass
// after reset.
module dynamic_eq_band_gain_computer_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [4:0]                         paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	input  logic                               item_valid,
	output logic                               item_ready,
	input  logic signed [deqbg_pkg::SAMPLE_W-1:0] dry_left,
	input  logic signed [deqbg_pkg::SAMPLE_W-1:0] dry_right,
	input  logic signed [deqbg_pkg::SAMPLE_W-1:0] eq_left,
	input  logic signed [deqbg_pkg::SAMPLE_W-1:0] eq_right,
	input  logic signed [deqbg_pkg::SAMPLE_W-1:0] detect_left,
	input  logic signed [deqbg_pkg::SAMPLE_W-1:0] detect_right,
	output logic                               result_valid,
	input  logic                               result_ready,
	output logic signed [deqbg_pkg::SAMPLE_W-1:0] out_left,
	output logic signed [deqbg_pkg::SAMPLE_W-1:0] out_right,
	output logic signed [deqbg_pkg::DB_W-1:0]     envelope_level_db,
	output logic signed [deqbg_pkg::GAIN_W-1:0]   target_gain_db
);

	// Sequencer states
	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_E1   = 5'd1;
	localparam logic [4:0] S_E2   = 5'd2;
	localparam logic [4:0] S_E3   = 5'd3;
	localparam logic [4:0] S_NORM = 5'd4;
	localparam logic [4:0] S_SQA  = 5'd5;
	localparam logic [4:0] S_SQB  = 5'd6;
	localparam logic [4:0] S_LQ   = 5'd7;
	localparam logic [4:0] S_LQ2  = 5'd8;
	localparam logic [4:0] S_ENV  = 5'd9;
	localparam logic [4:0] S_ENV2 = 5'd10;
	localparam logic [4:0] S_G0   = 5'd11;
	localparam logic [4:0] S_G1   = 5'd12;
	localparam logic [4:0] S_G2   = 5'd13;
	localparam logic [4:0] S_G3   = 5'd14;
	localparam logic [4:0] S_G4   = 5'd15;
	localparam logic [4:0] S_DIV  = 5'd16;
	localparam logic [4:0] S_GEND = 5'd17;
	localparam logic [4:0] S_SG   = 5'd18;
	localparam logic [4:0] S_SG2  = 5'd19;
	localparam logic [4:0] S_A0   = 5'd20;
	localparam logic [4:0] S_AEND = 5'd21;
	localparam logic [4:0] S_O1   = 5'd22;
	localparam logic [4:0] S_O2   = 5'd23;
	localparam logic [4:0] S_O3   = 5'd24;
	localparam logic [4:0] S_DONE = 5'd25;

	// Configuration registers
	logic [1:0]         mode_q;
	logic               rms_q;
	logic signed [15:0] thr_q;
	logic [14:0]        ratio_q;
	logic [12:0]        knee_q;
	logic [13:0]        range_q;
	logic [15:0]        atk_q;
	logic [15:0]        rel_q;

	// Beat registers and state
	logic [4:0]         state_q;
	logic [4:0]         ret_q;
	logic signed [23:0] dl_q, dr_q, ql_q, qr_q, detl_q, detr_q;
	logic signed [15:0] env_q, sg_q, lvl_q;
	logic signed [14:0] tgain_q;
	logic [47:0]        e_q;
	logic [5:0]         n_q;
	logic [31:0]        y_q;
	logic [15:0]        frac_q;
	logic [3:0]         cnt_q;
	logic [63:0]        prod_q;
	logic [47:0]        num_q;
	logic [31:0]        den_q;
	logic [47:0]        quo_q;
	logic [32:0]        rem_q;
	logic [5:0]         dcnt_q;
	logic [15:0]        f1_q, f2_q, f3_q, dk_q;
	logic               gneg_q;
	logic [17:0]        amt_q;
	logic signed [23:0] ol_q, or_q;
	logic               res_valid_q;
	logic signed [23:0] res_l_q, res_r_q;
	logic signed [15:0] res_env_q;
	logic signed [14:0] res_tg_q;

	logic wr_en;
	assign wr_en      = psel & penable & pwrite;
	assign pready     = 1'b1;
	assign item_ready = (state_q == S_IDLE);

	// Register read-back
	always_comb begin
		case (paddr[4:2])
			deqbg_pkg::REG_MODE:      prdata = {30'd0, mode_q};
			deqbg_pkg::REG_DETECT:    prdata = {31'd0, rms_q};
			deqbg_pkg::REG_THRESHOLD: prdata = {16'd0, thr_q};
			deqbg_pkg::REG_RATIO:     prdata = {17'd0, ratio_q};
			deqbg_pkg::REG_KNEE:      prdata = {19'd0, knee_q};
			deqbg_pkg::REG_RANGE:     prdata = {18'd0, range_q};
			deqbg_pkg::REG_ATTACK:    prdata = {16'd0, atk_q};
			deqbg_pkg::REG_RELEASE:   prdata = {16'd0, rel_q};
			default:                  prdata = 32'd0;
		endcase
	end

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= deqbg_pkg::MODE_OFF;
			rms_q   <= 1'b0;
			thr_q   <= -16'sd5120;
			ratio_q <= 15'd1024;
			knee_q  <= 13'd1536;
			range_q <= 14'd3072;
			atk_q   <= 16'd0;
			rel_q   <= 16'd0;
		end else if (wr_en) begin
			case (paddr[4:2])
				deqbg_pkg::REG_MODE:      mode_q  <= pwdata[1:0];
				deqbg_pkg::REG_DETECT:    rms_q   <= pwdata[0];
				deqbg_pkg::REG_THRESHOLD: thr_q   <= pwdata[15:0];
				deqbg_pkg::REG_RATIO:     ratio_q <= pwdata[14:0];
				deqbg_pkg::REG_KNEE:      knee_q  <= pwdata[12:0];
				deqbg_pkg::REG_RANGE:     range_q <= pwdata[13:0];
				deqbg_pkg::REG_ATTACK:    atk_q   <= pwdata[15:0];
				deqbg_pkg::REG_RELEASE:   rel_q   <= pwdata[15:0];
				default:                  mode_q  <= mode_q;
			endcase
		end
	end

	// Detector magnitudes
	logic [23:0] al_c, ar_c, pk_c;
	assign al_c = detl_q[23] ? (~detl_q + 24'd1) : detl_q;
	assign ar_c = detr_q[23] ? (~detr_q + 24'd1) : detr_q;
	assign pk_c = (al_c > ar_c) ? al_c : ar_c;

	// Logarithm to dB
	logic [5:0]  base_c;
	logic [21:0] neglq_c;
	logic [32:0] sq_c;
	logic [63:0] lq_sum_c;
	assign base_c   = rms_q ? 6'd47 : 6'd46;
	assign neglq_c  = {base_c - n_q, 16'd0} - {6'd0, frac_q};
	assign sq_c     = prod_q[63:31];
	assign lq_sum_c = prod_q + 64'h0000_0000_8000_0000;

	// Rounded product scaled by 2^-16, shared by smoothing and blending
	logic [31:0] rnd_c;
	assign rnd_c = deqbg_pkg::rnd_q16(prod_q[47:0]);

	// Smoothing of envelope and gain
	logic [16:0] env_d_c, env_dm_c, sg_d_c, sg_dm_c, sm_r_c;
	logic signed [15:0] tg16_c;
	logic [15:0] c_env_c, c_sg_c;
	assign tg16_c   = {tgain_q[14], tgain_q};
	assign env_d_c  = {env_q[15], env_q} - {lvl_q[15], lvl_q};
	assign env_dm_c = env_d_c[16] ? (~env_d_c + 17'd1) : env_d_c;
	assign c_env_c  = (lvl_q > env_q) ? atk_q : rel_q;
	assign sg_d_c   = {sg_q[15], sg_q} - {tg16_c[15], tg16_c};
	assign sg_dm_c  = sg_d_c[16] ? (~sg_d_c + 17'd1) : sg_d_c;
	assign c_sg_c   = (tg16_c < sg_q) ? atk_q : rel_q;
	assign sm_r_c   = rnd_c[16:0];

	// Gain curve terms
	logic signed [19:0] x20_c, t20_c, k20_c, ex20_c, v20_c;
	logic cond_c, hard_c, softx_c, exneg_c, rneg_c;
	logic [15:0] exm_c, d2_c, txm_c, rmag_c;
	logic [14:0] reff_c;
	logic [16:0] rm_c;
	assign x20_c   = {{4{env_q[15]}}, env_q};
	assign t20_c   = {{4{thr_q[15]}}, thr_q};
	assign k20_c   = {7'd0, knee_q};
	assign ex20_c  = x20_c - t20_c;
	assign v20_c   = ex20_c + {6'd0, range_q};
	assign cond_c  = (2 * x20_c) > (2 * t20_c - k20_c);
	assign hard_c  = (knee_q == 13'd0) || ((2 * x20_c) >= (2 * t20_c + k20_c));
	assign softx_c = (knee_q != 13'd0) && ((2 * ex20_c) < k20_c);
	assign exneg_c = ex20_c[19];
	assign exm_c   = exneg_c ? 16'(-ex20_c) : ex20_c[15:0];
	assign d2_c    = 16'(2 * ex20_c + k20_c);
	assign txm_c   = 16'(t20_c - x20_c);
	assign reff_c  = (ratio_q == 15'd0) ? 15'd1 : ratio_q;
	assign rm_c    = {2'd0, reff_c} - 17'd256;
	assign rneg_c  = rm_c[16];
	assign rmag_c  = rneg_c ? 16'(~rm_c + 17'd1) : rm_c[15:0];

	// Division step and quotient clamps
	logic [32:0] rem_sh_c;
	logic        rem_ge_c;
	logic [13:0] qg_c;
	logic [16:0] qa_c;
	assign rem_sh_c = {rem_q[31:0], quo_q[47]};
	assign rem_ge_c = rem_sh_c >= {1'b0, den_q};
	assign qg_c = (quo_q > {34'd0, range_q}) ? range_q : quo_q[13:0];
	assign qa_c = (quo_q > {31'd0, deqbg_pkg::COEFF_ONE}) ? deqbg_pkg::COEFF_ONE : quo_q[16:0];

	// Blend of dry and EQ samples
	logic        gate_c;
	logic [15:0] sgm_c;
	logic signed [24:0] dif_l_c, dif_r_c;
	logic [24:0] dml_c, dmr_c;
	logic signed [26:0] base_l_c, base_r_c, blend_c;
	logic [25:0] br_c;
	assign gate_c   = (mode_q == deqbg_pkg::MODE_GATE);
	assign sgm_c    = sg_q[15] ? (~sg_q + 16'd1) : sg_q;
	assign base_l_c = gate_c ? 27'sd0 : {{3{dl_q[23]}}, dl_q};
	assign base_r_c = gate_c ? 27'sd0 : {{3{dr_q[23]}}, dr_q};
	assign dif_l_c  = {ql_q[23], ql_q} - base_l_c[24:0];
	assign dif_r_c  = {qr_q[23], qr_q} - base_r_c[24:0];
	assign dml_c    = dif_l_c[24] ? (~dif_l_c + 25'd1) : dif_l_c;
	assign dmr_c    = dif_r_c[24] ? (~dif_r_c + 25'd1) : dif_r_c;
	assign br_c     = rnd_c[25:0];
	always_comb begin
		if (state_q == S_O2) begin
			blend_c = dif_l_c[24] ? base_l_c - $signed({1'b0, br_c})
				: base_l_c + $signed({1'b0, br_c});
		end else begin
			blend_c = dif_r_c[24] ? base_r_c - $signed({1'b0, br_c})
				: base_r_c + $signed({1'b0, br_c});
		end
	end

	// Operand selection for the shared multiplier
	logic [31:0] mul_a, mul_b;
	always_comb begin
		case (state_q)
			S_E1: begin
				mul_a = {8'd0, rms_q ? al_c : pk_c};
				mul_b = {8'd0, rms_q ? al_c : pk_c};
			end
			S_E2: begin
				mul_a = {8'd0, ar_c};
				mul_b = {8'd0, ar_c};
			end
			S_SQA: begin
				mul_a = y_q;
				mul_b = y_q;
			end
			S_LQ: begin
				mul_a = {10'd0, neglq_c};
				mul_b = {6'd0, deqbg_pkg::DB_PER_OCTAVE_Q24};
			end
			S_ENV: begin
				mul_a = {16'd0, c_env_c};
				mul_b = {15'd0, env_dm_c};
			end
			S_G1: begin
				mul_a = {16'd0, f1_q};
				mul_b = {16'd0, f2_q};
			end
			S_G2: begin
				mul_a = {17'd0, reff_c};
				mul_b = {16'd0, dk_q};
			end
			S_G3: begin
				mul_a = num_q[31:0];
				mul_b = {16'd0, f3_q};
			end
			S_SG: begin
				mul_a = {16'd0, c_sg_c};
				mul_b = {15'd0, sg_dm_c};
			end
			S_O1: begin
				mul_a = {7'd0, dml_c};
				mul_b = {14'd0, amt_q};
			end
			S_O2: begin
				mul_a = {7'd0, dmr_c};
				mul_b = {14'd0, amt_q};
			end
			default: begin
				mul_a = 32'd0;
				mul_b = 32'd0;
			end
		endcase
	end

	// Product register
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Sequencer and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			env_q       <= 16'sd0;
			sg_q        <= 16'sd0;
			res_valid_q <= 1'b0;
		end else begin
			// The output register fills from the done state and empties when taken
			if (state_q == S_DONE && (!res_valid_q || result_ready)) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						dl_q    <= dry_left;
						dr_q    <= dry_right;
						ql_q    <= eq_left;
						qr_q    <= eq_right;
						detl_q  <= detect_left;
						detr_q  <= detect_right;
						ol_q    <= eq_left;
						or_q    <= eq_right;
						tgain_q <= 15'sd0;
						state_q <= (mode_q == deqbg_pkg::MODE_OFF) ? S_DONE : S_E1;
					end
				end
				S_E1: begin
					state_q <= S_E2;
				end
				S_E2: begin
					e_q     <= prod_q[47:0];
					n_q     <= 6'd47;
					state_q <= rms_q ? S_E3 : S_NORM;
				end
				S_E3: begin
					e_q     <= e_q + prod_q[47:0];
					state_q <= S_NORM;
				end
				// Normalise the energy so that its top set bit lands on bit 47
				S_NORM: begin
					if (e_q == 48'd0) begin
						lvl_q   <= deqbg_pkg::DB_FLOOR;
						state_q <= S_ENV;
					end else if (e_q[47]) begin
						y_q     <= e_q[47:16];
						frac_q  <= 16'd0;
						cnt_q   <= 4'd0;
						state_q <= S_SQA;
					end else if (e_q[47:40] == 8'd0) begin
						e_q <= {e_q[39:0], 8'd0};
						n_q <= n_q - 6'd8;
					end else begin
						e_q <= {e_q[46:0], 1'b0};
						n_q <= n_q - 6'd1;
					end
				end
				S_SQA: begin
					state_q <= S_SQB;
				end
				// One fraction bit of the logarithm per squaring
				S_SQB: begin
					if (sq_c[32]) begin
						y_q    <= sq_c[32:1];
						frac_q <= {frac_q[14:0], 1'b1};
					end else begin
						y_q    <= sq_c[31:0];
						frac_q <= {frac_q[14:0], 1'b0};
					end
					cnt_q   <= cnt_q + 4'd1;
					state_q <= (cnt_q == 4'd15) ? S_LQ : S_SQA;
				end
				S_LQ: begin
					if (n_q >= base_c) begin
						lvl_q   <= 16'sd0;
						state_q <= S_ENV;
					end else begin
						state_q <= S_LQ2;
					end
				end
				S_LQ2: begin
					if (lq_sum_c[63:32] > 32'd25600) begin
						lvl_q <= deqbg_pkg::DB_FLOOR;
					end else begin
						lvl_q <= 16'(16'd0 - lq_sum_c[47:32]);
					end
					state_q <= S_ENV;
				end
				S_ENV: begin
					state_q <= S_ENV2;
				end
				S_ENV2: begin
					env_q <= 16'({lvl_q[15], lvl_q}
						+ (env_d_c[16] ? (~sm_r_c + 17'd1) : sm_r_c));
					state_q <= S_G0;
				end
				// Choose the factors of the gain curve for the mode and knee region
				S_G0: begin
					case (mode_q)
						deqbg_pkg::MODE_COMP: begin
							gneg_q <= !rneg_c;
							if (!cond_c || (hard_c && x20_c <= t20_c)) begin
								tgain_q <= 15'sd0;
								state_q <= S_SG;
							end else if (hard_c) begin
								f1_q    <= exm_c;
								f2_q    <= rmag_c;
								f3_q    <= 16'd1;
								dk_q    <= 16'd1;
								state_q <= S_G1;
							end else begin
								f1_q    <= d2_c;
								f2_q    <= d2_c;
								f3_q    <= rmag_c;
								dk_q    <= {knee_q, 3'd0};
								state_q <= S_G1;
							end
						end
						deqbg_pkg::MODE_EXP: begin
							gneg_q <= exneg_c ^ rneg_c;
							if (!cond_c) begin
								tgain_q <= 15'sd0;
								state_q <= S_SG;
							end else if (softx_c) begin
								f1_q    <= d2_c;
								f2_q    <= exm_c;
								f3_q    <= rmag_c;
								dk_q    <= {2'd0, knee_q, 1'b0};
								state_q <= S_G1;
							end else begin
								f1_q    <= exm_c;
								f2_q    <= rmag_c;
								f3_q    <= 16'd1;
								dk_q    <= 16'd1;
								state_q <= S_G1;
							end
						end
						deqbg_pkg::MODE_GATE: begin
							gneg_q <= 1'b1;
							if (x20_c < t20_c) begin
								f1_q    <= txm_c;
								f2_q    <= {1'b0, reff_c};
								f3_q    <= 16'd1;
								dk_q    <= 16'd1;
								state_q <= S_G1;
							end else begin
								tgain_q <= 15'sd0;
								state_q <= S_SG;
							end
						end
						default: begin
							gneg_q  <= 1'b0;
							tgain_q <= 15'sd0;
							state_q <= S_SG;
						end
					endcase
				end
				S_G1: begin
					state_q <= S_G2;
				end
				S_G2: begin
					num_q   <= prod_q[47:0];
					state_q <= S_G3;
				end
				S_G3: begin
					den_q   <= gate_c ? 32'd256 : prod_q[31:0];
					state_q <= S_G4;
				end
				S_G4: begin
					quo_q   <= prod_q[47:0] + {17'd0, den_q[31:1]};
					rem_q   <= 33'd0;
					dcnt_q  <= 6'd0;
					ret_q   <= S_GEND;
					state_q <= S_DIV;
				end
				// Restoring division, one quotient bit a cycle
				S_DIV: begin
					rem_q   <= rem_ge_c ? rem_sh_c - {1'b0, den_q} : rem_sh_c;
					quo_q   <= {quo_q[46:0], rem_ge_c};
					dcnt_q  <= dcnt_q + 6'd1;
					if (dcnt_q == 6'd47) begin
						state_q <= ret_q;
					end
				end
				S_GEND: begin
					if (mode_q == deqbg_pkg::MODE_EXP) begin
						tgain_q <= gneg_q ? 15'sd0 : {1'b0, qg_c};
					end else begin
						tgain_q <= gneg_q ? 15'(15'd0 - {1'b0, qg_c}) : 15'sd0;
					end
					state_q <= S_SG;
				end
				S_SG: begin
					state_q <= S_SG2;
				end
				S_SG2: begin
					sg_q <= 16'({tg16_c[15], tg16_c}
						+ (sg_d_c[16] ? (~sm_r_c + 17'd1) : sm_r_c));
					state_q <= S_A0;
				end
				// Blend amount: full EQ for an open gate or zero range, else zero or a division by the range
				S_A0: begin
					den_q  <= {18'd0, range_q};
					rem_q  <= 33'd0;
					dcnt_q <= 6'd0;
					ret_q  <= S_AEND;
					if (gate_c && !(x20_c < t20_c)) begin
						state_q <= S_DONE;
					end else if (range_q == 14'd0) begin
						amt_q   <= {1'b0, deqbg_pkg::COEFF_ONE};
						state_q <= S_O1;
					end else if (gate_c && (v20_c <= 20'sd0)) begin
						amt_q   <= 18'd0;
						state_q <= S_O1;
					end else if (gate_c) begin
						quo_q   <= {15'd0, v20_c[16:0], 16'd0} + {35'd0, range_q[13:1]};
						state_q <= S_DIV;
					end else begin
						quo_q   <= {16'd0, sgm_c, 16'd0} + {35'd0, range_q[13:1]};
						state_q <= S_DIV;
					end
				end
				S_AEND: begin
					if (gate_c) begin
						amt_q <= {1'b0, qa_c};
					end else if (mode_q == deqbg_pkg::MODE_COMP || sg_q[15]) begin
						amt_q <= {1'b0, deqbg_pkg::COEFF_ONE - qa_c};
					end else begin
						amt_q <= {1'b0, deqbg_pkg::COEFF_ONE} + {1'b0, qa_c};
					end
					state_q <= S_O1;
				end
				S_O1: begin
					state_q <= S_O2;
				end
				S_O2: begin
					ol_q    <= deqbg_pkg::sat_sample(blend_c);
					state_q <= S_O3;
				end
				S_O3: begin
					or_q    <= deqbg_pkg::sat_sample(blend_c);
					state_q <= S_DONE;
				end
				// Hand the result to the output register once it is free
				S_DONE: begin
					if (!res_valid_q || result_ready) begin
						res_l_q   <= ol_q;
						res_r_q   <= or_q;
						res_env_q <= env_q;
						res_tg_q  <= tgain_q;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid      = res_valid_q;
	assign out_left          = res_l_q;
	assign out_right         = res_r_q;
	assign envelope_level_db = res_env_q;
	assign target_gain_db    = res_tg_q;

endmodule

// ===== hdl/deqbg_checker.sv =====
// Port checker for the dynamic EQ band gain computer, bound to its top level.
// Depends on deqbg_pkg and on the top level's port list.
module deqbg_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  item_valid,
	input logic                                  item_ready,
	input logic                                  result_valid,
	input logic                                  result_ready,
	input logic signed [deqbg_pkg::SAMPLE_W-1:0] out_left,
	input logic signed [deqbg_pkg::DB_W-1:0]     envelope_level_db
);

	// A result beat stays offered until it is taken.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result beat withdrawn before it was taken");

	// A stalled result keeps its left sample.
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(out_left))
		else $error("stalled result payload changed");

	// Only one beat is worked on at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("input taken again while a beat is in progress");

	// The reported envelope stays within the detector floor and full scale.
	a_env_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (envelope_level_db <= 16'sd0)
			&& (envelope_level_db >= deqbg_pkg::DB_FLOOR))
		else $error("envelope level out of range");

endmodule

bind dynamic_eq_band_gain_computer_top deqbg_checker u_deqbg_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.item_valid        (item_valid),
	.item_ready        (item_ready),
	.result_valid      (result_valid),
	.result_ready      (result_ready),
	.out_left          (out_left),
	.envelope_level_db (envelope_level_db)
);

// ===== dv/dynamic_eq_band_gain_computer_top_test.sv =====
// Self-checking testbench for the dynamic EQ band gain computer top level.
// Drives stereo beats and register writes, predicts every result in place.
// Depends on deqbg_pkg and dynamic_eq_band_gain_computer_top.
`timescale 1ns / 1ps
module dynamic_eq_band_gain_computer_top_test;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int RAND_BEATS = 1430;

	// Register state kept by the testbench
	typedef struct {
		logic [1:0] mode;
		logic rms;
		logic [15:0] thresh;
		logic [14:0] ratio;
		logic [12:0] knee;
		logic [13:0] range;
		logic [15:0] attack;
		logic [15:0] release_c;
	} band_cfg_t;

	typedef struct {
		logic signed [23:0] dl, dr, ql, qr, tl, tr;
	} beat_in_t;

	typedef struct {
		logic signed [23:0] ol, orr;
		logic signed [15:0] env;
		logic signed [14:0] tg;
	} beat_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic item_valid = 1'b0;
	logic item_ready;
	logic signed [23:0] dry_left = '0, dry_right = '0, eq_left = '0, eq_right = '0;
	logic signed [23:0] detect_left = '0, detect_right = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic signed [23:0] out_left, out_right;
	logic signed [15:0] envelope_level_db;
	logic signed [14:0] target_gain_db;

	band_cfg_t cfg;
	longint env_state, gain_state;
	beat_out_t expected_beats[$];
	int send_idle_pct, recv_idle_pct;
	int cycles;
	bit failed;

	dynamic_eq_band_gain_computer_top u_dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic longint clampl(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// Division rounding to nearest, halves away from zero; den is positive.
	function automatic longint rdiv(longint num, longint den);
		if (num >= 0) return (num + den / 2) / den;
		return -((-num + den / 2) / den);
	endfunction

	// Detector level in dB, Q8.8, floored at -100 dB.
	function automatic longint detector_db(longint l, longint r, bit rms);
		longint unsigned al, ar, p, e, y, frac, mag;
		longint lq, db;
		int n;
		al = l < 0 ? -l : l;
		ar = r < 0 ? -r : r;
		p = al > ar ? al : ar;
		e = rms ? al * al + ar * ar : p * p;
		frac = 0;
		if (e == 0) return -25600;
		n = 63;
		while (((e >> n) & 1) == 0) n--;
		y = n >= 31 ? e >> (n - 31) : e << (31 - n);
		for (int i = 0; i < 16; i++) begin
			y = (y * y) >> 31;
			frac = frac << 1;
			if (y >= 64'h1_0000_0000) begin
				frac = frac | 1;
				y = y >> 1;
			end
		end
		lq = longint'(n - (46 + (rms ? 1 : 0))) * 65536 + longint'(frac);
		if (lq >= 0) return 0;
		mag = longint'(-lq) * 64'd50504453;
		mag = (mag + (64'd1 << 31)) >> 32;
		db = -longint'(mag);
		return db < -25600 ? -25600 : db;
	endfunction

	// Static curve: compress, expand or gate gain for envelope x.
	function automatic longint curve_gain(longint x);
		longint t, r, k, g, gain, d2, ex;
		t = longint'($signed(cfg.thresh));
		r = cfg.ratio == 0 ? 1 : longint'(cfg.ratio);
		k = cfg.knee;
		g = cfg.range;
		gain = 0;
		case (cfg.mode)
			deqbg_pkg::MODE_COMP: begin
				if (2 * x > 2 * t - k) begin
					if (k == 0 || 2 * x >= 2 * t + k)
						gain = x <= t ? 0 : rdiv((t - x) * (r - 256), r);
					else begin
						d2 = 2 * x - 2 * t + k;
						gain = rdiv(d2 * d2 * (256 - r), 8 * k * r);
					end
					gain = clampl(gain, -g, 0);
				end
			end
			deqbg_pkg::MODE_EXP: begin
				if (2 * x > 2 * t - k) begin
					ex = x - t;
					if (k > 0 && 2 * ex < k)
						gain = rdiv((2 * ex + k) * ex * (r - 256), 2 * k * r);
					else
						gain = rdiv(ex * (r - 256), r);
					gain = clampl(gain, 0, g);
				end
			end
			deqbg_pkg::MODE_GATE: begin
				if (x < t) gain = clampl(-rdiv((t - x) * r, 256), -g, 0);
			end
			default: gain = 0;
		endcase
		return gain;
	endfunction

	// Advance the band state by one beat and return the expected result.
	function automatic beat_out_t band_predict(beat_in_t b);
		beat_out_t o;
		longint ol, orr, tg, t, g, lvl, c, amt, sg;
		ol = b.ql;
		orr = b.qr;
		tg = 0;
		if (cfg.mode != deqbg_pkg::MODE_OFF) begin
			t = longint'($signed(cfg.thresh));
			g = cfg.range;
			lvl = detector_db(b.tl, b.tr, cfg.rms);
			c = lvl > env_state ? cfg.attack : cfg.release_c;
			env_state = lvl + rdiv(c * (env_state - lvl), 65536);
			tg = curve_gain(env_state);
			c = tg < gain_state ? cfg.attack : cfg.release_c;
			gain_state = tg + rdiv(c * (gain_state - tg), 65536);
			if (cfg.mode == deqbg_pkg::MODE_COMP || cfg.mode == deqbg_pkg::MODE_EXP) begin
				sg = gain_state;
				if (g == 0) amt = 65536;
				else if (cfg.mode == deqbg_pkg::MODE_COMP)
					amt = clampl(65536 - rdiv((sg < 0 ? -sg : sg) * 65536, g), 0, 65536);
				else
					amt = clampl(65536 + rdiv(sg * 65536, g), 0, 131072);
				ol = b.dl + rdiv((b.ql - b.dl) * amt, 65536);
				orr = b.dr + rdiv((b.qr - b.dr) * amt, 65536);
			end else if (env_state < t) begin
				amt = g == 0 ? 65536 : clampl(rdiv((env_state - t + g) * 65536, g), 0, 65536);
				ol = rdiv(b.ql * amt, 65536);
				orr = rdiv(b.qr * amt, 65536);
			end
		end
		o.ol = 24'(clampl(ol, -8388608, 8388607));
		o.orr = 24'(clampl(orr, -8388608, 8388607));
		o.env = 16'(env_state);
		o.tg = 15'(tg);
		return o;
	endfunction

	// Register write: setup cycle then access cycle.
	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			deqbg_pkg::REG_MODE: cfg.mode = val[1:0];
			deqbg_pkg::REG_DETECT: cfg.rms = val[0];
			deqbg_pkg::REG_THRESHOLD: cfg.thresh = val[15:0];
			deqbg_pkg::REG_RATIO: cfg.ratio = val[14:0];
			deqbg_pkg::REG_KNEE: cfg.knee = val[12:0];
			deqbg_pkg::REG_RANGE: cfg.range = val[13:0];
			deqbg_pkg::REG_ATTACK: cfg.attack = val[15:0];
			default: cfg.release_c = val[15:0];
		endcase
	endtask

	task automatic write_all(band_cfg_t c);
		reg_write(deqbg_pkg::REG_MODE, {30'd0, c.mode});
		reg_write(deqbg_pkg::REG_DETECT, {31'd0, c.rms});
		reg_write(deqbg_pkg::REG_THRESHOLD, {16'd0, c.thresh});
		reg_write(deqbg_pkg::REG_RATIO, {17'd0, c.ratio});
		reg_write(deqbg_pkg::REG_KNEE, {19'd0, c.knee});
		reg_write(deqbg_pkg::REG_RANGE, {18'd0, c.range});
		reg_write(deqbg_pkg::REG_ATTACK, {16'd0, c.attack});
		reg_write(deqbg_pkg::REG_RELEASE, {16'd0, c.release_c});
	endtask

	// Let the block drain before the registers change.
	task automatic wait_drained();
		item_valid <= 1'b0;
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// Present one beat and hold it until accepted; the prediction is queued then.
	task automatic send_beat(beat_in_t b, bit has_known, beat_out_t known);
		beat_out_t p;
		if ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		item_valid <= 1'b1;
		dry_left <= b.dl;
		dry_right <= b.dr;
		eq_left <= b.ql;
		eq_right <= b.qr;
		detect_left <= b.tl;
		detect_right <= b.tr;
		do @(posedge clk); while (!item_ready);
		p = band_predict(b);
		if (has_known && p != known) begin
			$error("directed row disagrees with predictor: %p vs %p", known, p);
			failed = 1'b1;
		end
		expected_beats.push_back(p);
	endtask

	// Receive side: random stalls and field checks.
	always @(posedge clk) begin
		beat_out_t e;
		if (arst_n) begin
			result_ready <= $urandom_range(99) >= recv_idle_pct;
			if (result_valid && result_ready) begin
				if (expected_beats.size() == 0) begin
					$error("result with no beat outstanding");
					failed = 1'b1;
				end else begin
					e = expected_beats.pop_front();
					if (out_left !== e.ol) begin
						$error("out_left expected %0d actual %0d", e.ol, out_left);
						failed = 1'b1;
					end
					if (out_right !== e.orr) begin
						$error("out_right expected %0d actual %0d", e.orr, out_right);
						failed = 1'b1;
					end
					if (envelope_level_db !== e.env) begin
						$error("envelope_level_db expected %0d actual %0d", e.env,
							envelope_level_db);
						failed = 1'b1;
					end
					if (target_gain_db !== e.tg) begin
						$error("target_gain_db expected %0d actual %0d", e.tg,
							target_gain_db);
						failed = 1'b1;
					end
				end
			end
		end
	end

	function automatic logic signed [23:0] rand_sample();
		case ($urandom_range(5))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return $signed(24'($urandom_range(255))) - 24'sd128;
			3: return 24'($urandom >> ($urandom_range(31)));
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic band_cfg_t rand_cfg();
		band_cfg_t c;
		c.mode = 2'($urandom_range(3));
		c.rms = 1'($urandom_range(1));
		c.thresh = 16'(-$urandom_range(25600));
		c.ratio = $urandom_range(3) == 0 ? 15'($urandom_range(32767))
			: 15'($urandom_range(256, 25600));
		c.knee = $urandom_range(2) == 0 ? 13'($urandom) : 13'($urandom_range(6144));
		c.range = $urandom_range(3) == 0 ? 14'($urandom) : 14'($urandom_range(12288));
		c.attack = $urandom_range(3) == 0 ? 16'hFFFF : 16'($urandom);
		c.release_c = $urandom_range(3) == 0 ? 16'h0000 : 16'($urandom);
		return c;
	endfunction

	// Directed rows: config change flag, config, beat, known result if any.
	typedef struct {
		bit set_cfg;
		band_cfg_t c;
		beat_in_t b;
		bit has_known;
		beat_out_t known;
	} stim_row_t;

	initial begin
		stim_row_t rows[$];
		stim_row_t r;
		band_cfg_t c;
		beat_in_t b;
		int phase;
		cfg = '{deqbg_pkg::MODE_OFF, 1'b0, -16'sd5120, 15'd1024, 13'd1536, 14'd3072,
			16'd0, 16'd0};
		env_state = 0;
		gain_state = 0;
		send_idle_pct = 33;
		recv_idle_pct = 79;
		cycles = 0;
		failed = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Band off after reset: EQ samples pass, envelope and gain zero.
		r = '{0, cfg, '{24'sd5, -24'sd5, 24'sh7FFFFF, 24'sh800000, 24'sd1, 24'sd1},
			1, '{24'sh7FFFFF, 24'sh800000, 16'sd0, 15'sd0}};
		rows.push_back(r);
		// Compress, zero detector: floor level, well below threshold, no gain.
		c = cfg;
		c.mode = deqbg_pkg::MODE_COMP;
		r = '{1, c, '{24'sd100, 24'sd200, 24'sd300, 24'sd400, 24'sd0, 24'sd0},
			1, '{24'sd300, 24'sd400, -16'sd25600, 15'sd0}};
		rows.push_back(r);
		// Full-scale then smaller detector beats in both detector styles and each active mode.
		for (int m = 1; m < 4; m++) begin
			for (int rm = 0; rm < 2; rm++) begin
				c.mode = 2'(m);
				c.rms = 1'(rm);
				r = '{1, c, '{24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh7FFFFF,
					24'sh800000, 24'sh7FFFFF}, 0, '{0, 0, 0, 0}};
				rows.push_back(r);
				r.set_cfg = 0;
				r.b.tl = 24'sd3;
				r.b.tr = -24'sd70000;
				rows.push_back(r);
			end
		end
		// Zero range, zero ratio, hard knee, odd knee, ratio below one.
		c = '{deqbg_pkg::MODE_COMP, 1'b0, -16'sd2560, 15'd0, 13'd0, 14'd0, 16'd0, 16'd0};
		r = '{1, c, '{24'sd1000, -24'sd1000, 24'sd7, -24'sd7, 24'sh400000, 24'sd0},
			0, '{0, 0, 0, 0}};
		rows.push_back(r);
		c = '{deqbg_pkg::MODE_GATE, 1'b0, 16'sd0, 15'd0, 13'd1, 14'd0, 16'hFFFF, 16'hFFFF};
		r.c = c;
		rows.push_back(r);
		c = '{deqbg_pkg::MODE_EXP, 1'b1, -16'sd25600, 15'd128, 13'd6143, 14'd12288,
			16'h8000, 16'h0001};
		r.c = c;
		rows.push_back(r);
		r.set_cfg = 0;
		r.b.tl = 24'sd12345;
		rows.push_back(r);
		c = '{deqbg_pkg::MODE_COMP, 1'b1, -16'sd1000, 15'd32767, 13'd8191, 14'd16383,
			16'd0, 16'hFFFF};
		r = '{1, c, '{24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh7FFFFF, 24'sd900,
			-24'sd9000}, 0, '{0, 0, 0, 0}};
		rows.push_back(r);
		c.mode = deqbg_pkg::MODE_EXP;
		rows.push_back('{1, c, r.b, 0, r.known});
		c.mode = deqbg_pkg::MODE_GATE;
		c.range = 14'd12288;
		rows.push_back('{1, c, r.b, 0, r.known});

		foreach (rows[i]) begin
			if (rows[i].set_cfg) begin
				wait_drained();
				write_all(rows[i].c);
			end
			send_beat(rows[i].b, rows[i].has_known, rows[i].known);
		end

		// Random part in three idling phases, registers re-drawn every so often.
		for (int i = 0; i < RAND_BEATS; i++) begin
			phase = i * 3 / RAND_BEATS;
			send_idle_pct = phase == 0 ? 33 : (phase == 1 ? 79 : 0);
			recv_idle_pct = phase == 0 ? 79 : (phase == 1 ? 33 : 0);
			if (i % 40 == 0) begin
				wait_drained();
				write_all(rand_cfg());
			end
			b.dl = rand_sample();
			b.dr = rand_sample();
			b.ql = rand_sample();
			b.qr = rand_sample();
			b.tl = rand_sample();
			b.tr = $urandom_range(3) == 0 ? b.tl : rand_sample();
			send_beat(b, 0, '{0, 0, 0, 0});
		end

		item_valid <= 1'b0;
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (!failed)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

// ===== files.f =====
hdl/deqbg_pkg.sv
hdl/dynamic_eq_band_gain_computer_top.sv
hdl/deqbg_checker.sv
dv/dynamic_eq_band_gain_computer_top_test.sv
